/* hw/rtl/cgapu_pkg.sv */
// Shared constants and types for the compact GA probability update core.
`timescale 1ns / 1ps

package cgapu_pkg;

  localparam int unsigned MAX_PLAYERS_DEF    = 8;
  localparam int unsigned PRECISION_DEF      = 4;
  localparam int unsigned PROB_FRAC_BITS_DEF = 15;

  localparam int unsigned PROB_PORT_W  = 16;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned PLAYERS_W    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned NUM_POS      = 4;

  localparam logic [STEP_W-1:0]    STEP_RESET    = 16'd328;
  localparam logic [PLAYERS_W-1:0] PLAYERS_RESET = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYERS_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    CMD_COMPETE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

endpackage

/* hw/rtl/compact_ga_probability_update_core.sv */
// Top level of the compact GA probability table with read-modify-write update.
`timescale 1ns / 1ps

// One entry per (player, gene) holds PRECISION Q1.15 probabilities in a single
// synchronous RAM word. Compete and read items stream at one item per cycle
// while the output is taken and no restart or pass is in progress: the word is
// read at accept, updated and written back when the item leaves the item stage,
// and a write-to-read forward covers the same entry arriving back to back. The
// output register lets a new item enter while a result waits. A restart item
// rewrites every entry to one half before its result appears. After reset the
// same fill pass runs and no item is accepted until it ends. A write of
// players_in_use starts a recount pass over the RAM that also holds off items;
// the configuration port is always ready.
module compact_ga_probability_update_core
  import cgapu_pkg::*;
#(
  parameter int unsigned MAX_PLAYERS    = MAX_PLAYERS_DEF,
  parameter int unsigned PRECISION      = PRECISION_DEF,
  parameter int unsigned PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [2:0]             player_i,
  input  logic [2:0]             gene_i,
  input  logic signed [15:0]     result_a_i,
  input  logic signed [15:0]     result_b_i,
  input  logic [3:0]             bits_a_i,
  input  logic [3:0]             bits_b_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PROB_PORT_W-1:0] prob_pos0_o,
  output logic [PROB_PORT_W-1:0] prob_pos1_o,
  output logic [PROB_PORT_W-1:0] prob_pos2_o,
  output logic [PROB_PORT_W-1:0] prob_pos3_o,
  output logic                   updated_o,
  output logic                   converged_o,
  output logic                   bad_index_o
);

  localparam int unsigned PW      = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
  localparam int unsigned AW      = 2 * PW;
  localparam int unsigned DEPTH   = 1 << AW;
  localparam int unsigned PROB_W  = PROB_FRAC_BITS + 1;
  localparam int unsigned MW      = PRECISION * PROB_W;
  localparam int unsigned IW      = 6;
  localparam int unsigned SW      = 18;
  localparam int unsigned UW      = $clog2(PRECISION + 1);
  localparam int unsigned MAX_UNS = MAX_PLAYERS * MAX_PLAYERS * PRECISION;
  localparam int unsigned CNT_W   = $clog2(MAX_UNS + 1);
  localparam int unsigned PROB_ONE = 1 << PROB_FRAC_BITS;

  localparam logic [PW-1:0]     P_LAST    = PW'(MAX_PLAYERS - 1);
  localparam logic [PROB_W-1:0] HALF_W    = PROB_W'(PROB_ONE >> 1);
  localparam logic [PROB_W-1:0] ONE_W     = PROB_W'(PROB_ONE);
  localparam logic [SW-1:0]     ONE_X     = SW'(PROB_ONE);
  localparam logic [SW-1:0]     STEP_ZERO = SW'(65536);

  function automatic logic is_counted(input logic [IW-1:0] p, input logic [IW-1:0] g,
                                      input logic [IW-1:0] n);
    logic in_group;
    logic p0_last;
    in_group = (p + g) < n;
    p0_last  = (p == '0) && ((g + IW'(1)) == n);
    return in_group && !p0_last;
  endfunction

  function automatic logic [UW-1:0] unsettled(input logic [MW-1:0] w);
    logic [UW-1:0] c;
    logic [PROB_W-1:0] v;
    c = '0;
    for (int k = 0; k < PRECISION; k++) begin
      v = w[k*PROB_W +: PROB_W];
      if (v != '0 && v != ONE_W) begin
        c = c + UW'(1);
      end
    end
    return c;
  endfunction

  // Configuration
  logic [STEP_W-1:0]    step_q;
  logic [PLAYERS_W-1:0] players_q;
  logic                 recount_req_q, recount_req_d;
  logic                 cfg_acc;

  // Item stage
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_started_q, s1_started_d;
  logic [1:0]           s1_cmd_q;
  logic [2:0]           s1_player_q, s1_gene_q;
  logic signed [15:0]   s1_ra_q, s1_rb_q;
  logic [3:0]           s1_ba_q, s1_bb_q;
  logic                 fwd_q;
  logic [MW-1:0]        fwd_data_q;

  // Sweep (fill or recount)
  logic                 sw_run_q, sw_run_d;
  logic                 sw_fill_q, sw_fill_d;
  logic [PW-1:0]        sw_p_q, sw_p_d, sw_g_q, sw_g_d;
  logic                 sw_pend_q;
  logic [PW-1:0]        sw_pp_q, sw_pg_q;
  logic                 sw_busy, sw_start;
  logic [CNT_W-1:0]     uns_q, uns_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic [NUM_POS-1:0][PROB_PORT_W-1:0] out_prob_q, out_prob_d;
  logic                              out_upd_q, out_conv_q, out_bad_q;

  // RAM
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr, s1_addr, sw_addr, in_addr;
  logic [MW-1:0]        ram_wdata, ram_rdata;

  logic [IW-1:0]        n_act;
  logic                 s1_bad, s1_ctd, s1_upd, s1_is_rst, s1_fire, out_free, in_acc;
  logic [MW-1:0]        cur_word, new_word;
  logic [3:0]           win_bits, diff_bits;
  logic [SW-1:0]        step_x;
  logic [NUM_POS-1:0][PROB_PORT_W-1:0] prob_ext;

  assign n_act = (IW'(players_q) > IW'(MAX_PLAYERS)) ? IW'(MAX_PLAYERS) : IW'(players_q);

  assign s1_addr = {PW'(s1_player_q), PW'(s1_gene_q)};
  assign in_addr = {PW'(player_i), PW'(gene_i)};
  assign sw_addr = {sw_p_q, sw_g_q};

  assign s1_bad    = !((IW'(s1_player_q) + IW'(s1_gene_q)) < n_act);
  assign s1_ctd    = is_counted(IW'(s1_player_q), IW'(s1_gene_q), n_act);
  assign s1_is_rst = (s1_cmd_q == CMD_RESTART);
  assign s1_upd    = (s1_cmd_q == CMD_COMPETE) && !s1_bad && (s1_ra_q != s1_rb_q);
  assign win_bits  = (s1_ra_q > s1_rb_q) ? s1_ba_q : s1_bb_q;
  assign diff_bits = (s1_ba_q ^ s1_bb_q) & {4{s1_upd}};
  assign cur_word  = fwd_q ? fwd_data_q : ram_rdata;
  assign step_x    = (step_q == '0) ? STEP_ZERO : SW'(step_q);

  // Move each differing position one step toward the winner.
  always_comb begin
    logic [SW-1:0] v;
    logic [SW-1:0] t;
    new_word = cur_word;
    for (int k = 0; k < PRECISION; k++) begin
      v = SW'(cur_word[k*PROB_W +: PROB_W]);
      if (win_bits[3-k]) begin
        t = ((v + step_x) > ONE_X) ? ONE_X : (v + step_x);
      end else begin
        t = (v >= step_x) ? (v - step_x) : '0;
      end
      if (t < step_x) begin
        t = '0;
      end
      if (diff_bits[3-k]) begin
        new_word[k*PROB_W +: PROB_W] = t[PROB_W-1:0];
      end
    end
  end

  assign sw_busy  = sw_run_q || sw_pend_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_fire  = s1_valid_q && out_free && (!s1_is_rst || (s1_started_q && !sw_busy));
  assign in_ready_o = !sw_busy && !recount_req_q && (!s1_valid_q || s1_fire);
  assign in_acc   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc  = cfg_valid_i;

  assign sw_start = !sw_busy && ((s1_valid_q && s1_is_rst && !s1_started_q) ||
                                 (recount_req_q && !s1_valid_q));

  // RAM port steering: sweeps and item traffic never overlap.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr;
    ram_wdata = new_word;
    ram_re    = 1'b0;
    ram_raddr = in_addr;
    if (sw_run_q && sw_fill_q) begin
      ram_we    = 1'b1;
      ram_waddr = sw_addr;
      ram_wdata = {PRECISION{HALF_W}};
    end else if (s1_fire && s1_upd) begin
      ram_we = 1'b1;
    end
    if (sw_run_q && !sw_fill_q) begin
      ram_re    = 1'b1;
      ram_raddr = sw_addr;
    end else if (in_acc) begin
      ram_re = 1'b1;
    end
  end

  cgapu_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_prob_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sweep control and unsettled count.
  always_comb begin
    logic [CNT_W-1:0] add_fill;
    logic [CNT_W-1:0] add_rd;
    sw_run_d  = sw_run_q;
    sw_fill_d = sw_fill_q;
    sw_p_d    = sw_p_q;
    sw_g_d    = sw_g_q;
    add_fill  = '0;
    add_rd    = '0;
    if (sw_run_q && sw_fill_q && is_counted(IW'(sw_p_q), IW'(sw_g_q), n_act)) begin
      add_fill = CNT_W'(PRECISION);
    end
    if (sw_pend_q && is_counted(IW'(sw_pp_q), IW'(sw_pg_q), n_act)) begin
      add_rd = CNT_W'(unsettled(ram_rdata));
    end
    uns_d = uns_q + add_fill + add_rd;
    if (s1_fire && s1_upd && s1_ctd) begin
      uns_d = uns_q + CNT_W'(unsettled(new_word)) - CNT_W'(unsettled(cur_word));
    end
    if (sw_run_q) begin
      if (sw_g_q == P_LAST) begin
        sw_g_d = '0;
        sw_p_d = sw_p_q + PW'(1);
        if (sw_p_q == P_LAST) begin
          sw_run_d = 1'b0;
        end
      end else begin
        sw_g_d = sw_g_q + PW'(1);
      end
    end
    if (sw_start) begin
      sw_run_d  = 1'b1;
      sw_fill_d = s1_valid_q && s1_is_rst;
      sw_p_d    = '0;
      sw_g_d    = '0;
      uns_d     = '0;
    end
  end

  always_comb begin
    recount_req_d = recount_req_q;
    if (sw_start) begin
      recount_req_d = 1'b0;
    end
    if (cfg_acc && cfg_index_i == CFG_PLAYERS_IN_USE) begin
      recount_req_d = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d   = s1_valid_q;
    s1_started_d = s1_started_q;
    if (sw_start && s1_valid_q && s1_is_rst) begin
      s1_started_d = 1'b1;
    end
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d   = 1'b1;
      s1_started_d = 1'b0;
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < NUM_POS; gk++) begin : g_pos
      if (gk < PRECISION) begin : g_used
        assign prob_ext[gk] = s1_bad ? '0 :
                              s1_is_rst ? PROB_PORT_W'(HALF_W) :
                              PROB_PORT_W'(new_word[gk*PROB_W +: PROB_W]);
      end else begin : g_unused
        assign prob_ext[gk] = '0;
      end
    end
  endgenerate

  always_comb begin
    out_valid_d = out_valid_q;
    out_prob_d  = out_prob_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
      out_prob_d  = prob_ext;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= STEP_RESET;
      players_q     <= PLAYERS_RESET;
      recount_req_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      s1_started_q  <= 1'b0;
      fwd_q         <= 1'b0;
      sw_run_q      <= 1'b1;
      sw_fill_q     <= 1'b1;
      sw_p_q        <= '0;
      sw_g_q        <= '0;
      sw_pend_q     <= 1'b0;
      uns_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_acc && cfg_index_i == CFG_STEP_SIZE) begin
        step_q <= cfg_data_i;
      end
      if (cfg_acc && cfg_index_i == CFG_PLAYERS_IN_USE) begin
        players_q <= cfg_data_i[PLAYERS_W-1:0];
      end
      recount_req_q <= recount_req_d;
      s1_valid_q    <= s1_valid_d;
      s1_started_q  <= s1_started_d;
      // Forward the word written in the same cycle the entry is read.
      if (in_acc) begin
        fwd_q <= ram_we && (ram_waddr == in_addr);
      end
      sw_run_q    <= sw_run_d;
      sw_fill_q   <= sw_fill_d;
      sw_p_q      <= sw_p_d;
      sw_g_q      <= sw_g_d;
      sw_pend_q   <= sw_run_q && !sw_fill_q;
      uns_q       <= uns_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q    <= cmd_i;
      s1_player_q <= player_i;
      s1_gene_q   <= gene_i;
      s1_ra_q     <= result_a_i;
      s1_rb_q     <= result_b_i;
      s1_ba_q     <= bits_a_i;
      s1_bb_q     <= bits_b_i;
      fwd_data_q  <= ram_wdata;
    end
    sw_pp_q <= sw_p_q;
    sw_pg_q <= sw_g_q;
    out_prob_q <= out_prob_d;
    if (s1_fire) begin
      out_upd_q  <= s1_upd;
      out_conv_q <= (uns_d == '0);
      out_bad_q  <= s1_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign prob_pos0_o = out_prob_q[0];
  assign prob_pos1_o = out_prob_q[1];
  assign prob_pos2_o = out_prob_q[2];
  assign prob_pos3_o = out_prob_q[3];
  assign updated_o   = out_upd_q;
  assign converged_o = out_conv_q;
  assign bad_index_o = out_bad_q;

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_upd) |-> !(sw_run_q && sw_fill_q))
    else $error("item write-back collides with fill pass");

  a_recount_on_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_PLAYERS_IN_USE)
      |=> (recount_req_q || sw_run_q))
    else $error("players_in_use write did not schedule a recount");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uns_q <= CNT_W'(MAX_UNS))
    else $error("unsettled count out of range");

  a_sweep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sw_run_q) |-> (uns_q == '0))
    else $error("sweep started without clearing the count");
`endif

endmodule

/* hw/rtl/cgapu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cgapu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/prob_table_checker.sv */
// Checker for the compact GA probability table: predicts each reply and compares it.
`timescale 1ns / 1ps

module prob_table_checker
  import cgapu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             cmd_i,
  input  logic [2:0]             player_i,
  input  logic [2:0]             gene_i,
  input  logic signed [15:0]     result_a_i,
  input  logic signed [15:0]     result_b_i,
  input  logic [3:0]             bits_a_i,
  input  logic [3:0]             bits_b_i,

  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [PROB_PORT_W-1:0] prob_pos0_i,
  input  logic [PROB_PORT_W-1:0] prob_pos1_i,
  input  logic [PROB_PORT_W-1:0] prob_pos2_i,
  input  logic [PROB_PORT_W-1:0] prob_pos3_i,
  input  logic                   updated_i,
  input  logic                   converged_i,
  input  logic                   bad_index_i,

  output int                     fail_count_o,
  output int                     backlog_o
);

  localparam int unsigned PROB_ONE  = 1 << PROB_FRAC_BITS_DEF;
  localparam int unsigned PROB_HALF = PROB_ONE >> 1;
  localparam int unsigned MAX_P     = MAX_PLAYERS_DEF;

  typedef struct packed {
    logic [NUM_POS-1:0][PROB_PORT_W-1:0] pos;
    logic                                updated;
    logic                                converged;
    logic                                bad_index;
  } table_reply_t;

  logic [PROB_PORT_W-1:0] odds [MAX_P][MAX_P][NUM_POS];
  logic [STEP_W-1:0]      step_q;
  logic [PLAYERS_W-1:0]   players_q;
  table_reply_t           forecast_q [$];

  function automatic int live_players();
    return (players_q > MAX_P) ? int'(MAX_P) : int'(players_q);
  endfunction

  // Player 0's last gene is kept out of the count.
  function automatic int count_unsettled();
    int n;
    int c;
    n = live_players();
    c = 0;
    for (int p = 0; p < n; p++) begin
      for (int g = 0; g < n - p; g++) begin
        if (!(p == 0 && g + 1 >= n)) begin
          for (int k = 0; k < PRECISION_DEF; k++) begin
            if (odds[p][g][k] != 0 && odds[p][g][k] != PROB_ONE) c++;
          end
        end
      end
    end
    return c & 'h1FF;
  endfunction

  function automatic table_reply_t predict_entry(
    input logic [1:0]         cmd,
    input logic [2:0]         pl,
    input logic [2:0]         gn,
    input logic signed [15:0] ra,
    input logic signed [15:0] rb,
    input logic [3:0]         ba,
    input logic [3:0]         bb
  );
    table_reply_t r;
    int           n;
    int unsigned  stp;
    int unsigned  v;
    logic [3:0]   win;
    logic [3:0]   diff;
    logic         bad;
    n   = live_players();
    stp = (step_q == '0) ? 32'd65536 : 32'(step_q);
    bad = !(int'(pl) < n && int'(gn) < n - int'(pl));
    r   = '0;
    if (cmd == CMD_RESTART) begin
      for (int p = 0; p < MAX_P; p++)
        for (int g = 0; g < MAX_P; g++)
          for (int k = 0; k < NUM_POS; k++) odds[p][g][k] = PROB_PORT_W'(PROB_HALF);
    end else if (cmd == CMD_COMPETE && !bad && ra != rb) begin
      win = (ra > rb) ? ba : bb;
      diff = ba ^ bb;
      r.updated = 1'b1;
      // bit 3 of the gene bits maps to position 0
      for (int k = 0; k < PRECISION_DEF; k++) begin
        if (diff[3-k]) begin
          v = odds[pl][gn][k];
          if (win[3-k]) v = (v + stp > PROB_ONE) ? PROB_ONE : v + stp;
          else v = (v >= stp) ? v - stp : 0;
          if (v < stp) v = 0;
          odds[pl][gn][k] = PROB_PORT_W'(v);
        end
      end
    end
    for (int k = 0; k < NUM_POS; k++) begin
      if (!bad && k < PRECISION_DEF) r.pos[k] = odds[pl][gn][k];
    end
    r.converged = (count_unsettled() == 0);
    r.bad_index = bad;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t seen;
    table_reply_t want;
    table_reply_t fresh;
    if (!rst_ni) begin
      for (int p = 0; p < MAX_P; p++)
        for (int g = 0; g < MAX_P; g++)
          for (int k = 0; k < NUM_POS; k++) odds[p][g][k] = PROB_PORT_W'(PROB_HALF);
      step_q       = STEP_RESET;
      players_q    = PLAYERS_RESET;
      fail_count_o = 0;
      forecast_q.delete();
    end else begin
      // results first: a reply can never belong to an item accepted at the same edge
      if (out_valid_i && out_ready_i) begin
        seen.pos       = {prob_pos3_i, prob_pos2_i, prob_pos1_i, prob_pos0_i};
        seen.updated   = updated_i;
        seen.converged = converged_i;
        seen.bad_index = bad_index_i;
        if (forecast_q.size() == 0) begin
          report_mismatch("reply with no item outstanding", 1, 0);
        end else begin
          want = forecast_q.pop_front();
          for (int k = 0; k < NUM_POS; k++) begin
            if (seen.pos[k] !== want.pos[k]) begin
              report_mismatch($sformatf("prob_pos%0d", k), seen.pos[k], want.pos[k]);
            end
          end
          if (seen.updated !== want.updated)
            report_mismatch("updated", seen.updated, want.updated);
          if (seen.converged !== want.converged)
            report_mismatch("converged", seen.converged, want.converged);
          if (seen.bad_index !== want.bad_index)
            report_mismatch("bad_index", seen.bad_index, want.bad_index);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_STEP_SIZE) step_q = cfg_data_i[STEP_W-1:0];
        else if (cfg_index_i == CFG_PLAYERS_IN_USE) players_q = cfg_data_i[PLAYERS_W-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        fresh = predict_entry(cmd_i, player_i, gene_i, result_a_i, result_b_i,
                              bits_a_i, bits_b_i);
        forecast_q = {forecast_q, fresh};
      end
    end
    backlog_o = forecast_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the probability table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import cgapu_pkg::*;

  localparam int                   QUIET_LIMIT = 2000;
  localparam logic [1:0]           CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             cmd_i       = '0;
  logic [2:0]             player_i    = '0;
  logic [2:0]             gene_i      = '0;
  logic signed [15:0]     result_a_i  = '0;
  logic signed [15:0]     result_b_i  = '0;
  logic [3:0]             bits_a_i    = '0;
  logic [3:0]             bits_b_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [PROB_PORT_W-1:0] prob_pos0_o;
  logic [PROB_PORT_W-1:0] prob_pos1_o;
  logic [PROB_PORT_W-1:0] prob_pos2_o;
  logic [PROB_PORT_W-1:0] prob_pos3_o;
  logic                   updated_o;
  logic                   converged_o;
  logic                   bad_index_o;

  int fail_count;
  int backlog;
  int items_sent  = 0;
  int replies_got = 0;
  int live_n      = 3;
  int quiet_cycles = 0;
  bit pace_in     = 1'b0;
  bit pace_out    = 1'b0;

  compact_ga_probability_update_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .player_i    (player_i),
    .gene_i      (gene_i),
    .result_a_i  (result_a_i),
    .result_b_i  (result_b_i),
    .bits_a_i    (bits_a_i),
    .bits_b_i    (bits_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prob_pos0_o (prob_pos0_o),
    .prob_pos1_o (prob_pos1_o),
    .prob_pos2_o (prob_pos2_o),
    .prob_pos3_o (prob_pos3_o),
    .updated_o   (updated_o),
    .converged_o (converged_o),
    .bad_index_o (bad_index_o)
  );

  prob_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .player_i     (player_i),
    .gene_i       (gene_i),
    .result_a_i   (result_a_i),
    .result_b_i   (result_b_i),
    .bits_a_i     (bits_a_i),
    .bits_b_i     (bits_b_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prob_pos0_i  (prob_pos0_o),
    .prob_pos1_i  (prob_pos1_o),
    .prob_pos2_i  (prob_pos2_o),
    .prob_pos3_i  (prob_pos3_o),
    .updated_i    (updated_o),
    .converged_i  (converged_o),
    .bad_index_i  (bad_index_o),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: when pace_out is set, stall for a random gap before taking each reply.
  initial begin : receiver
    int gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = pace_out ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      replies_got++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high across back-to-back items; drop it only for a gap.
  task automatic send_item(
    input logic [1:0]         cmd,
    input logic [2:0]         pl,
    input logic [2:0]         gn,
    input logic signed [15:0] ra,
    input logic signed [15:0] rb,
    input logic [3:0]         ba,
    input logic [3:0]         bb
  );
    int gap;
    gap = pace_in ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    player_i   <= pl;
    gene_i     <= gn;
    result_a_i <= ra;
    result_b_i <= rb;
    bits_a_i   <= ba;
    bits_b_i   <= bb;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (replies_got != items_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [STEP_W-1:0] stp, input logic [PLAYERS_W-1:0] np,
                           input bit poke_spare);
    drain();
    write_reg(CFG_STEP_SIZE, stp);
    write_reg(CFG_PLAYERS_IN_USE, CFG_DATA_W'(np));
    if (poke_spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    live_n = (np > MAX_PLAYERS_DEF) ? int'(MAX_PLAYERS_DEF) : int'(np);
  endtask

  initial begin : stimulus
    int unsigned        pick;
    logic [1:0]         cmd;
    logic [2:0]         pl;
    logic [2:0]         gn;
    logic signed [15:0] ra;
    logic signed [15:0] rb;
    logic [STEP_W-1:0]  stp;
    logic [3:0]         np;

    do @(posedge clk_i); while (!rst_ni);

    // directed part at the reset settings: three players, step 328
    pace_in  = 1'b1;
    pace_out = 1'b1;
    send_item(CMD_READ,    3'd0, 3'd0, 16'sd0,      16'sd0,      4'h0, 4'h0);
    send_item(CMD_COMPETE, 3'd0, 3'd0, 16'sd32767,  -16'sd32768, 4'hF, 4'h0);
    send_item(CMD_COMPETE, 3'd0, 3'd0, -16'sd32768, 16'sd32767,  4'hF, 4'h0);
    send_item(CMD_COMPETE, 3'd1, 3'd0, 16'sd5,      16'sd5,      4'hA, 4'h5);
    send_item(CMD_COMPETE, 3'd1, 3'd1, 16'sd1,      16'sd0,      4'hA, 4'h5);
    send_item(CMD_COMPETE, 3'd2, 3'd0, -16'sd1,     16'sd0,      4'hF, 4'h0);
    send_item(CMD_COMPETE, 3'd0, 3'd2, 16'sd100,    -16'sd100,   4'h6, 4'h9);
    send_item(CMD_COMPETE, 3'd2, 3'd1, 16'sd3,      16'sd2,      4'hF, 4'h0);
    send_item(CMD_READ,    3'd7, 3'd7, 16'sd0,      16'sd0,      4'h0, 4'h0);
    send_item(CMD_COMPETE, 3'd3, 3'd0, 16'sd9,      16'sd2,      4'hF, 4'h0);
    send_item(CMD_UNUSED,  3'd1, 3'd0, 16'sd9,      16'sd2,      4'hF, 4'h0);
    send_item(CMD_COMPETE, 3'd1, 3'd0, 16'sd7,      16'sd8,      4'h9, 4'h9);
    send_item(CMD_RESTART, 3'd7, 3'd7, 16'sd0,      16'sd0,      4'h0, 4'h0);
    send_item(CMD_RESTART, 3'd0, 3'd1, 16'sd0,      16'sd0,      4'h0, 4'h0);
    // same entry back to back
    pace_in  = 1'b0;
    send_item(CMD_COMPETE, 3'd1, 3'd0, 16'sd4,      16'sd3,      4'hC, 4'h3);
    send_item(CMD_COMPETE, 3'd1, 3'd0, 16'sd4,      16'sd3,      4'hC, 4'h3);
    send_item(CMD_READ,    3'd1, 3'd0, 16'sd0,      16'sd0,      4'h0, 4'h0);

    // register extremes
    configure(16'd32768, 4'd8, 1'b0);
    send_item(CMD_COMPETE, 3'd0, 3'd0, 16'sd1,      16'sd0,      4'hF, 4'h0);
    send_item(CMD_COMPETE, 3'd7, 3'd0, 16'sd1,      16'sd0,      4'h0, 4'hF);
    configure(16'd0, 4'd15, 1'b0);
    send_item(CMD_COMPETE, 3'd3, 3'd2, -16'sd2,     16'sd2,      4'h5, 4'hA);
    configure(16'd65535, 4'd0, 1'b0);
    send_item(CMD_COMPETE, 3'd0, 3'd0, 16'sd1,      16'sd0,      4'hF, 4'h0);
    configure(16'd1, 4'd1, 1'b0);
    send_item(CMD_COMPETE, 3'd0, 3'd0, 16'sd1,      16'sd0,      4'hF, 4'h0);

    // random part, several settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin stp = 16'd16384; np = 4'd2; end
        1: begin stp = 16'd8192;  np = 4'd3; end
        2: begin stp = 16'd1;     np = 4'd8; end
        3: begin stp = 16'd32768; np = 4'd4; end
        4: begin stp = 16'd0;     np = 4'd5; end
        5: begin stp = 16'd65535; np = 4'd2; end
        default: begin
          case ($urandom_range(0, 5))
            0: stp = 16'($urandom_range(1, 1023));
            1: stp = 16'($urandom_range(4096, 32768));
            2: stp = 16'd32768;
            3: stp = 16'd0;
            4: stp = 16'($urandom_range(32769, 65535));
            default: stp = 16'd16384;
          endcase
          np = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
        end
      endcase
      configure(stp, np, ph == 6);
      pace_in  = (ph % 4 == 0) || (ph % 4 == 2);
      pace_out = (ph % 4 == 0) || (ph % 4 == 3);
      for (int i = 0; i < 92; i++) begin
        // now and then hold off until the table has answered everything
        if ($urandom_range(0, 39) == 0) drain();
        pick = $urandom_range(0, 99);
        pl   = 3'($urandom);
        gn   = 3'($urandom);
        ra   = 16'($urandom);
        rb   = ($urandom_range(0, 7) == 0) ? ra : 16'($urandom);
        if (pick < 4) cmd = CMD_RESTART;
        else if (pick < 7) cmd = CMD_UNUSED;
        else if (pick < 17) cmd = CMD_READ;
        else cmd = CMD_COMPETE;
        if (pick >= 25 && live_n > 0) begin
          pl = 3'($urandom_range(0, live_n - 1));
          gn = 3'($urandom_range(0, live_n - 1 - int'(pl)));
        end
        send_item(cmd, pl, gn, ra, rb, 4'($urandom), 4'($urandom));
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && backlog == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/cgapu_pkg.sv
hw/rtl/cgapu_ram.sv
hw/rtl/compact_ga_probability_update_core.sv
tb/sv/prob_table_checker.sv
tb/sv/testbench.sv
